### hw/rtl/mci2t_pkg.sv
// Shared types and constants for the motor current i2t monitor.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package mci2t_pkg;

  localparam int NUM_JOINTS = 4;
  localparam int JOINT_W    = 2;
  localparam int ACC_W      = 31;
  localparam int LIMIT_W    = 15;
  localparam int COEF_W     = 16;
  localparam int CUR_W      = 16;
  localparam int MAG_W      = 15;
  localparam int MUL_A_W    = 16;
  localparam int MUL_B_W    = 31;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ADDR_W     = 5;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [COEF_W-1:0]  GAIN_RESET   = 16'd3198;
  localparam logic [COEF_W-1:0]  DECAY_RESET  = 16'd64789;
  localparam logic [COEF_W-1:0]  WEIGHT_RESET = 16'd1459;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd1600;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_GAIN   = 3'd1,
    REG_DECAY  = 3'd2,
    REG_WEIGHT = 3'd3,
    REG_LIMIT0 = 3'd4,
    REG_LIMIT1 = 3'd5,
    REG_LIMIT2 = 3'd6,
    REG_LIMIT3 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                                mode;
    logic [COEF_W-1:0]                   gain;
    logic [COEF_W-1:0]                   decay;
    logic [COEF_W-1:0]                   weight;
    logic [NUM_JOINTS-1:0][LIMIT_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic scale;
    logic mul_a;
    logic mul_b;
    logic finish;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_MUL_A,
    S_MUL_B,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/mci2t_regs.sv
// Configuration register file behind the APB-style port.
// Depends on mci2t_pkg for the register map and the cfg_t bundle.
`default_nettype none

module mci2t_regs
  import mci2t_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_MODE:   cfg_nxt.mode     = pwdata[0];
        REG_GAIN:   cfg_nxt.gain     = pwdata[COEF_W-1:0];
        REG_DECAY:  cfg_nxt.decay    = pwdata[COEF_W-1:0];
        REG_WEIGHT: cfg_nxt.weight   = pwdata[COEF_W-1:0];
        REG_LIMIT0: cfg_nxt.limit[0] = pwdata[LIMIT_W-1:0];
        REG_LIMIT1: cfg_nxt.limit[1] = pwdata[LIMIT_W-1:0];
        REG_LIMIT2: cfg_nxt.limit[2] = pwdata[LIMIT_W-1:0];
        REG_LIMIT3: cfg_nxt.limit[3] = pwdata[LIMIT_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode   <= 1'b0;
      cfg_r.gain   <= GAIN_RESET;
      cfg_r.decay  <= DECAY_RESET;
      cfg_r.weight <= WEIGHT_RESET;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        cfg_r.limit[i] <= LIMIT_RESET;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {31'd0, cfg_r.mode};
      REG_GAIN:   prdata = {16'd0, cfg_r.gain};
      REG_DECAY:  prdata = {16'd0, cfg_r.decay};
      REG_WEIGHT: prdata = {16'd0, cfg_r.weight};
      REG_LIMIT0: prdata = {17'd0, cfg_r.limit[0]};
      REG_LIMIT1: prdata = {17'd0, cfg_r.limit[1]};
      REG_LIMIT2: prdata = {17'd0, cfg_r.limit[2]};
      REG_LIMIT3: prdata = {17'd0, cfg_r.limit[3]};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/mci2t_ctrl.sv
// Sequencer for the monitor: steps one word through scale, two multiply
// passes and the final update, and owns the result valid flag. Uses mci2t_pkg.
`default_nettype none

module mci2t_ctrl
  import mci2t_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCALE))
    else $error("accepted word did not start the scale step");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished word not presented on the result side");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.finish)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### hw/rtl/mci2t_datapath.sv
// Datapath: per-joint current and accumulator state, one shared 16x31
// multiplier, the add/clamp logic and the result register. Uses mci2t_pkg.
`default_nettype none

module mci2t_datapath
  import mci2t_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire cfg_t               cfg,
  input  wire logic [JOINT_W-1:0] in_joint,
  input  wire logic [14:0]        in_raw_sample,
  input  wire logic               in_positive_direction,
  output logic signed [CUR_W-1:0] out_current_ma,
  output logic [ACC_W-1:0]        out_accumulator
);

  logic signed [CUR_W-1:0] present_r  [NUM_JOINTS];
  logic [ACC_W-1:0]        acc_r      [NUM_JOINTS];

  logic [JOINT_W-1:0]      joint_r;
  logic [14:0]             raw_r;
  logic                    pos_r;
  logic [MAG_W-1:0]        mag_r;
  logic [MAG_W-1:0]        prev_mag_r;
  logic                    e_pos_r;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W:0]         sum_r;
  logic signed [CUR_W-1:0] cur_ma_r;
  logic [ACC_W-1:0]        acc_out_r;

  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic signed [CUR_W-1:0] cur_new;
  logic signed [CUR_W-1:0] present_sel;
  logic [CUR_W-1:0]        present_abs;
  logic [CUR_W-1:0]        excess;
  logic [CUR_W-1:0]        excess_abs;
  logic [CUR_W-1:0]        mag_sum;
  logic [ACC_W-1:0]        acc_old;
  logic [31:0]             acc_up;
  logic [29:0]             sq;
  logic [31:0]             filt;
  logic [ACC_W-1:0]        acc_new;

  assign mul_p = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};

  assign cur_new     = pos_r ? $signed({1'b0, mag_r}) : -$signed({1'b0, mag_r});
  assign present_sel = present_r[joint_r];
  assign present_abs = present_sel[CUR_W-1] ? -present_sel : present_sel;
  assign excess      = {1'b0, mag_r} - {1'b0, cfg.limit[joint_r]};
  assign excess_abs  = excess[CUR_W-1] ? -excess : excess;
  assign mag_sum     = {1'b0, mag_r} + {1'b0, prev_mag_r};
  assign acc_old     = acc_r[joint_r];
  assign sq          = prod_r[29:0];
  assign acc_up      = {1'b0, acc_old} + {2'b0, sq};
  assign filt        = sum_r[47:16];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.scale) begin
      mul_a = cfg.gain;
      mul_b = {16'd0, raw_r};
    end else if (cmd.mul_a) begin
      if (cfg.mode) begin
        mul_a = excess_abs;
        mul_b = {15'd0, excess_abs};
      end else begin
        mul_a = cfg.decay;
        mul_b = acc_old;
      end
    end else if (cmd.mul_b) begin
      mul_a = cfg.weight;
      mul_b = {15'd0, mag_sum};
    end
  end

  always_comb begin
    if (!cfg.mode) begin
      acc_new = filt[31] ? ACC_MAX : filt[ACC_W-1:0];
    end else if (e_pos_r) begin
      acc_new = acc_up[31] ? ACC_MAX : acc_up[ACC_W-1:0];
    end else if ({1'b0, sq} > acc_old) begin
      acc_new = '0;
    end else begin
      acc_new = acc_old - {1'b0, sq};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        present_r[i]  <= '0;
        acc_r[i]      <= '0;
      end
    end else begin
      if (cmd.mul_a) begin
        present_r[joint_r]  <= cur_new;
      end
      if (cmd.finish) begin
        acc_r[joint_r] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      joint_r <= in_joint;
      raw_r   <= in_raw_sample;
      pos_r   <= in_positive_direction;
    end
    if (cmd.scale) begin
      mag_r      <= mul_p[30:16];
      prev_mag_r <= present_abs[MAG_W-1:0];
    end
    if (cmd.mul_a) begin
      prod_r  <= mul_p;
      e_pos_r <= !excess[CUR_W-1] && (excess != '0);
    end
    if (cmd.mul_b) begin
      // a1*acc plus a2*256*(|prev|+|cur|)
      sum_r <= {1'b0, prod_r} + {7'd0, mul_p[32:0], 8'd0};
    end
    if (cmd.finish) begin
      cur_ma_r  <= present_r[joint_r];
      acc_out_r <= acc_new;
    end
  end

  assign out_current_ma  = cur_ma_r;
  assign out_accumulator = acc_out_r;

endmodule

`default_nettype wire

### hw/rtl/motor_current_i2t_monitor.sv
// Top level of the motor current i2t monitor: register file, sequencer and datapath.
// Depends on mci2t_pkg, mci2t_regs, mci2t_ctrl and mci2t_datapath.
//
// Each word names a joint, a raw converter sample and a direction; the block
// returns the signed current in mA and the joint's updated heat accumulator
// (a first-order filter of the current magnitude, or an i2t sum of the signed
// square of the excess over the joint's limit, clamped to 0..2^31-1). A word is
// taken while the sequencer is idle and its result lands in the result register
// after four steps of the sequencer, three of which use the single shared
// 16x31 multiplier (scale, then decay or excess square, then input weight).
// The input is stalled during those steps, so a new word is taken only once the
// sequencer is back in idle; a result stalled at the output holds the last step
// until it is taken. Configuration sits at byte addresses 4*i and must be
// written only while no word is in flight.
`default_nettype none

module motor_current_i2t_monitor
  import mci2t_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [JOINT_W-1:0] in_joint,
  input  wire logic [14:0]        in_raw_sample,
  input  wire logic               in_positive_direction,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [CUR_W-1:0] out_current_ma,
  output logic [ACC_W-1:0]        out_accumulator,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t cfg;
  cmd_t cmd;

  mci2t_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mci2t_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mci2t_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg                   (cfg),
    .in_joint              (in_joint),
    .in_raw_sample         (in_raw_sample),
    .in_positive_direction (in_positive_direction),
    .out_current_ma        (out_current_ma),
    .out_accumulator       (out_accumulator)
  );

endmodule

`default_nettype wire
